### rtl/core/sfd_pkg.sv
package sfd_pkg;

  localparam int unsigned IO_W = 64;
  localparam int unsigned SKID_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIV_ZERO = 2'd2
  } sfd_status_t;

  typedef struct packed {
    logic        xn;
    logic        yn;
    sfd_status_t status;
  } sfd_ctl_t;

  typedef struct packed {
    logic signed [IO_W-1:0] quotient;
    logic signed [IO_W-1:0] remainder;
    sfd_status_t            status;
  } sfd_res_t;

endpackage

### rtl/core/sfd_if.sv
interface sfd_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [sfd_pkg::IO_W-1:0]  dividend;
  logic signed [sfd_pkg::IO_W-1:0]  divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface sfd_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sfd_pkg::IO_W-1:0]  quotient;
  logic signed [sfd_pkg::IO_W-1:0]  remainder;
  logic [1:0]                       status;

  modport source (output valid, output quotient, output remainder, output status, input ready);
  modport sink (input valid, input quotient, input remainder, input status, output ready);
endinterface

### rtl/core/sfd_pre.sv
module sfd_pre #(
  parameter int unsigned W = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [sfd_pkg::IO_W-1:0]     in_dividend,
  input  logic [sfd_pkg::IO_W-1:0]     in_divisor,
  output logic                         valid_r,
  output sfd_pkg::sfd_ctl_t            ctl_r,
  output logic [W-1:0]                 uy_r,
  output logic [W-1:0]                 rem_r,
  output logic [W-1:0]                 dq_r
);

  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]      x;
  logic [W-1:0]      y;
  sfd_pkg::sfd_ctl_t ctl_nxt;
  logic [W-1:0]      ux_nxt;
  logic [W-1:0]      uy_nxt;

  always_comb begin
    x = in_dividend[W-1:0];
    y = in_divisor[W-1:0];
    ctl_nxt.xn = x[W-1];
    ctl_nxt.yn = y[W-1];
    ux_nxt = x[W-1] ? (W'(0) - x) : x;
    uy_nxt = y[W-1] ? (W'(0) - y) : y;
    priority if (y == '0) begin
      ctl_nxt.status = sfd_pkg::ST_DIV_ZERO;
    end else if ((y == '1) && (x == WMIN)) begin
      ctl_nxt.status = sfd_pkg::ST_OVERFLOW;
    end else begin
      ctl_nxt.status = sfd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      ctl_r <= ctl_nxt;
      uy_r  <= uy_nxt;
      rem_r <= '0;
      dq_r  <= ux_nxt;
    end
  end

endmodule

### rtl/core/sfd_step.sv
module sfd_step #(
  parameter int unsigned W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  sfd_pkg::sfd_ctl_t in_ctl,
  input  logic [W-1:0]      in_uy,
  input  logic [W-1:0]      in_rem,
  input  logic [W-1:0]      in_dq,
  output logic              valid_r,
  output sfd_pkg::sfd_ctl_t ctl_r,
  output logic [W-1:0]      uy_r,
  output logic [W-1:0]      rem_r,
  output logic [W-1:0]      dq_r
);

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         fits;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] dq_nxt;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {in_rem, in_dq[W-1]};
    diff    = trial - {1'b0, in_uy};
    fits    = (trial >= {1'b0, in_uy});
    rem_nxt = fits ? diff[W-1:0] : trial[W-1:0];
    dq_nxt  = {in_dq[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      ctl_r <= in_ctl;
      uy_r  <= in_uy;
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

endmodule

### rtl/core/sfd_post.sv
module sfd_post #(
  parameter int unsigned W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  sfd_pkg::sfd_ctl_t in_ctl,
  input  logic [W-1:0]      in_uy,
  input  logic [W-1:0]      in_rem,
  input  logic [W-1:0]      in_dq,
  output logic              valid_r,
  output sfd_pkg::sfd_res_t res_r
);

  logic              neg;
  logic              rnz;
  logic [W-1:0]      tq;
  logic [W-1:0]      tr;
  logic [W-1:0]      gap;
  sfd_pkg::sfd_res_t res_nxt;

  // floor correction: quotient -(q+1) is ~q, remainder moves by the divisor
  always_comb begin
    neg = in_ctl.xn ^ in_ctl.yn;
    rnz = (in_rem != '0);
    gap = in_uy - in_rem;
    if (neg) begin
      tq = rnz ? ~in_dq : (W'(0) - in_dq);
    end else begin
      tq = in_dq;
    end
    if (neg && rnz) begin
      tr = in_ctl.yn ? (W'(0) - gap) : gap;
    end else begin
      tr = in_ctl.xn ? (W'(0) - in_rem) : in_rem;
    end
    res_nxt.status = in_ctl.status;
    if (in_ctl.status == sfd_pkg::ST_OK) begin
      res_nxt.quotient  = sfd_pkg::IO_W'(signed'(tq));
      res_nxt.remainder = sfd_pkg::IO_W'(signed'(tr));
    end else begin
      res_nxt.quotient  = '0;
      res_nxt.remainder = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      res_r <= res_nxt;
    end
  end

endmodule

### rtl/core/sfd_skid.sv
module sfd_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfd_pkg::sfd_res_t push_data,
  output logic              room,
  sfd_out_if.source         out_chan
);

  sfd_pkg::sfd_res_t slot_r [sfd_pkg::SKID_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign room               = (cnt_r != 2'(sfd_pkg::SKID_DEPTH));
  assign pop                = out_chan.valid && out_chan.ready;
  assign out_chan.valid     = (cnt_r != 2'd0);
  assign out_chan.quotient  = slot_r[rd_ptr_r].quotient;
  assign out_chan.remainder = slot_r[rd_ptr_r].remainder;
  assign out_chan.status    = slot_r[rd_ptr_r].status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(sfd_pkg::SKID_DEPTH))
    else $error("output queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(sfd_pkg::SKID_DEPTH)) |-> !push)
    else $error("transaction pushed into full output queue");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("output queue pointers disagree while empty");

endmodule

### rtl/core/signed_floor_divmod.sv
// channel   dir  fields                          transaction when
// in_chan   in   dividend[63:0], divisor[63:0]   valid && ready
// out_chan  out  quotient, remainder, status     valid && ready
//
// one transaction per cycle sustained while the output queue has room;
// one restoring subtract per stage across DATA_WIDTH divide stages,
// plus operand, correction and output queue registers
// rst_n (synchronous) clears stage valid bits and the output queue
// a two-entry output queue absorbs stalls; the whole pipeline holds
// while the queue is full and nothing is lost or repeated
module signed_floor_divmod #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  sfd_in_if.sink     in_chan,
  sfd_out_if.source  out_chan
);

  localparam int unsigned W = DATA_WIDTH;

  logic              en;
  logic              valid_s [W+1];
  sfd_pkg::sfd_ctl_t ctl_s   [W+1];
  logic [W-1:0]      uy_s    [W+1];
  logic [W-1:0]      rem_s   [W+1];
  logic [W-1:0]      dq_s    [W+1];
  logic              post_valid;
  sfd_pkg::sfd_res_t post_res;

  assign in_chan.ready = en;

  sfd_pre #(.W(W)) u_pre (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_chan.valid),
    .in_dividend (in_chan.dividend),
    .in_divisor  (in_chan.divisor),
    .valid_r     (valid_s[0]),
    .ctl_r       (ctl_s[0]),
    .uy_r        (uy_s[0]),
    .rem_r       (rem_s[0]),
    .dq_r        (dq_s[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_step
    sfd_step #(.W(W)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (valid_s[i]),
      .in_ctl   (ctl_s[i]),
      .in_uy    (uy_s[i]),
      .in_rem   (rem_s[i]),
      .in_dq    (dq_s[i]),
      .valid_r  (valid_s[i+1]),
      .ctl_r    (ctl_s[i+1]),
      .uy_r     (uy_s[i+1]),
      .rem_r    (rem_s[i+1]),
      .dq_r     (dq_s[i+1])
    );
  end

  sfd_post #(.W(W)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (valid_s[W]),
    .in_ctl   (ctl_s[W]),
    .in_uy    (uy_s[W]),
    .in_rem   (rem_s[W]),
    .in_dq    (dq_s[W]),
    .valid_r  (post_valid),
    .res_r    (post_res)
  );

  sfd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (post_valid && en),
    .push_data (post_res),
    .room      (en),
    .out_chan  (out_chan)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status != sfd_pkg::ST_OK))
      |-> ((out_chan.quotient == '0) && (out_chan.remainder == '0)))
    else $error("error transaction carries nonzero result");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(valid_s[0]) && $stable(post_valid))
    else $error("pipeline moved during stall");

endmodule
